// ===== sv/rhh_pkg.sv =====
// shared types, codes and hash helpers for the robin hood hash table
package rhh_pkg;

   // defaults for the top-level parameters
   localparam int SLOTS_DEF      = 1024;
   localparam int KEY_BYTES_DEF  = 8;
   localparam int VALUE_BITS_DEF = 32;

   // fnv-1a 64-bit constants
   localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
   localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   // operation codes
   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_PUT    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_ABSENT   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   // register indexes
   localparam logic [0:0] CSR_CAP  = 1'b0;
   localparam logic [0:0] CSR_FILL = 1'b1;

   // one hashed operation passed from front to back
   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [3:0]  key_len;
      logic [31:0] value;
      logic [63:0] hash;
   } job_type;

   // one fnv-1a round: xor in a byte, multiply by the prime as shift plus small product
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x * 64'h1b3);
   endfunction

endpackage

// ===== sv/rhh_front.sv =====
// front end: takes requests, masks the key and hashes it one byte per cycle
module rhh_front #(
   parameter int KEY_BYTES = rhh_pkg::KEY_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_func,
   input  logic [63:0]      in_key,
   input  logic [3:0]       in_key_len,
   input  logic [31:0]      in_value,
   output logic             out_valid,
   input  logic             out_ready,
   output rhh_pkg::job_type out_job
);
   import rhh_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_HASH = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]  st_ff, st_in;
   job_type     job_ff, job_in;
   logic [63:0] sh_ff, sh_in;
   logic [3:0]  left_ff, left_in;
   logic [3:0]  keep;
   logic [63:0] kmask;

   // clamp the length and build the byte mask of the kept key bytes
   always_comb begin
      keep = (in_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_len;
      for (int b = 0; b < 8; b++) begin
         kmask[b*8 +: 8] = (4'(b) < keep) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      st_in    = st_ff;
      job_in   = job_ff;
      sh_in    = sh_ff;
      left_in  = left_ff;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (st_ff)
         F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               job_in.func    = in_func;
               job_in.key     = in_key & kmask;
               job_in.key_len = keep;
               job_in.value   = in_value;
               job_in.hash    = FNV_BASIS;
               sh_in          = in_key & kmask;
               left_in        = keep;
               st_in          = (keep == 4'd0) ? F_PUSH : F_HASH;
            end
         end
         F_HASH: begin
            job_in.hash = fnv_step(job_ff.hash, sh_ff[7:0]);
            sh_in       = sh_ff >> 8;
            left_in     = left_ff - 4'd1;
            if (left_ff == 4'd1) begin
               st_in = F_PUSH;
            end
         end
         F_PUSH: begin
            out_valid = 1'b1;
            if (out_ready) begin
               st_in = F_IDLE;
            end
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      job_ff  <= job_in;
      sh_ff   <= sh_in;
      left_ff <= left_in;
   end

   assign out_job = job_ff;

endmodule

// ===== sv/rhh_fifo.sv =====
// two-entry queue of hashed operations between front and back
module rhh_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             push_ready,
   input  rhh_pkg::job_type push_job,
   input  logic             pop,
   output logic             pop_valid,
   output rhh_pkg::job_type pop_job
);
   import rhh_pkg::*;

   job_type    ent_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_job    = ent_ff[rptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= ~rptr_ff;
         end
      end
      if (do_push) begin
         ent_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/rhh_back.sv =====
// back end: slot memories, probe walk sequencer, registers and result register
module rhh_back #(
   parameter int SLOTS      = rhh_pkg::SLOTS_DEF,
   parameter int KEY_BYTES  = rhh_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_pop,
   input  rhh_pkg::job_type job,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [10:0]      csr_wdata,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_value,
   output logic [63:0]      rsp_hash,
   output logic [10:0]      rsp_total
);
   import rhh_pkg::*;

   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = IW + 1;
   localparam int MW    = 5 + IW;
   localparam int KW    = KEY_BYTES * 8;
   localparam int LGMAX = $clog2(SLOTS + 1) - 1;
   localparam int CMPW  = (CW > 11) ? CW : 11;

   localparam logic [2:0] B_CLR  = 3'd0;
   localparam logic [2:0] B_IDLE = 3'd1;
   localparam logic [2:0] B_RD   = 3'd2;
   localparam logic [2:0] B_CHK  = 3'd3;
   localparam logic [2:0] B_FIN  = 3'd4;

   localparam logic [1:0] M_FIND = 2'd0;
   localparam logic [1:0] M_INS  = 2'd1;
   localparam logic [1:0] M_DEL  = 2'd2;

   // slot memories
   logic [KW-1:0]         key_mem  [SLOTS];
   logic [VALUE_BITS-1:0] val_mem  [SLOTS];
   logic [MW-1:0]         meta_mem [SLOTS];
   logic [KW-1:0]         rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [MW-1:0]         rd_meta;

   logic [2:0]            st_ff, st_in;
   logic [1:0]            mode_ff, mode_in;
   job_type               job_ff, job_in;
   logic [IW-1:0]         idx_ff, idx_in, hole_ff, hole_in, clr_ff, clr_in;
   logic [CW-1:0]         step_ff, step_in, mp_ff, mp_in, cnt_ff, cnt_in;
   logic [KW-1:0]         mk_ff, mk_in;
   logic [VALUE_BITS-1:0] mv_ff, mv_in;
   logic [3:0]            ml_ff, ml_in;
   logic                  sweep_ff, sweep_in;
   logic [2:0]            status_ff, status_in;
   logic [31:0]           rv_ff, rv_in;
   logic [3:0]            cap_ff, cap_in;
   logic [10:0]           fill_ff, fill_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic [63:0]           rsp_hash_ff, rsp_hash_in;
   logic [10:0]           rsp_total_ff, rsp_total_in;

   logic                  kv_we, val_we, meta_we, miss, full, used;
   logic [IW-1:0]         waddr, mask, idx_next;
   logic [KW-1:0]         wkey;
   logic [VALUE_BITS-1:0] wval;
   logic [MW-1:0]         wmeta;
   logic [IW-1:0]         sp;
   logic [3:0]            rlen;
   logic [4:0]            lg;
   logic [CW-1:0]         n;

   // slots in use from the capacity register
   always_comb begin
      lg = (cap_ff == 4'd0) ? 5'd1 : {1'b0, cap_ff};
      if (lg > 5'(LGMAX)) begin
         lg = 5'(LGMAX);
      end
      n    = CW'(1) << lg;
      mask = IW'(n - CW'(1));
      full = (CMPW'(cnt_ff) >= CMPW'(fill_ff)) || (cnt_ff >= n);
   end

   assign used     = rd_meta[0];
   assign rlen     = rd_meta[4:1];
   assign sp       = rd_meta[MW-1:5];
   assign idx_next = (idx_ff + IW'(1)) & mask;

   always_comb begin
      st_in     = st_ff;
      mode_in   = mode_ff;
      job_in    = job_ff;
      idx_in    = idx_ff;
      hole_in   = hole_ff;
      clr_in    = clr_ff;
      step_in   = step_ff;
      mp_in     = mp_ff;
      cnt_in    = cnt_ff;
      mk_in     = mk_ff;
      mv_in     = mv_ff;
      ml_in     = ml_ff;
      sweep_in  = sweep_ff;
      status_in = status_ff;
      rv_in     = rv_ff;
      cap_in    = cap_ff;
      fill_in   = fill_ff;
      job_pop   = 1'b0;
      miss      = 1'b0;
      kv_we     = 1'b0;
      val_we    = 1'b0;
      meta_we   = 1'b0;
      waddr     = idx_ff;
      wkey      = mk_ff;
      wval      = mv_ff;
      wmeta     = {IW'(mp_ff), ml_ff, 1'b1};
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_total_in  = rsp_total_ff;

      case (st_ff)
         // clearing pass over every slot
         B_CLR: begin
            meta_we = 1'b1;
            waddr   = clr_ff;
            wmeta   = '0;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == IW'(SLOTS - 1)) begin
               st_in = B_IDLE;
            end
         end
         // take the next operation from the queue
         B_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job;
               rv_in   = 32'd0;
               if (job.func == FUNC_CLEAR) begin
                  cnt_in    = '0;
                  status_in = ST_CLEARED;
                  sweep_in  = 1'b1;
                  st_in     = B_FIN;
               end else begin
                  idx_in  = job.hash[IW-1:0] & mask;
                  step_in = '0;
                  mp_in   = '0;
                  mode_in = M_FIND;
                  mk_in   = KW'(job.key);
                  mv_in   = VALUE_BITS'(job.value);
                  ml_in   = job.key_len;
                  st_in   = B_RD;
               end
            end
         end
         // slot read in flight; stop once the walk has covered every slot in use
         B_RD: begin
            if (step_ff == n) begin
               case (mode_ff)
                  M_FIND: begin
                     miss = 1'b1;
                  end
                  M_INS: begin
                     cnt_in    = cnt_ff + CW'(1);
                     status_in = ST_INSERTED;
                     st_in     = B_FIN;
                  end
                  default: begin
                     meta_we = 1'b1;
                     waddr   = hole_ff;
                     wmeta   = '0;
                     st_in   = B_FIN;
                  end
               endcase
            end else begin
               st_in = B_CHK;
            end
         end
         // examine the slot just read
         B_CHK: begin
            case (mode_ff)
               M_FIND: begin
                  if (!used || CW'(sp) < step_ff) begin
                     miss = 1'b1;
                  end else if (rlen == ml_ff && rd_key == mk_ff) begin
                     status_in = ST_FOUND;
                     case (job_ff.func)
                        FUNC_LOOKUP: begin
                           rv_in = 32'(rd_val);
                           st_in = B_FIN;
                        end
                        FUNC_PUT: begin
                           rv_in  = 32'(rd_val);
                           val_we = 1'b1;
                           st_in  = B_FIN;
                        end
                        default: begin
                           hole_in = idx_ff;
                           idx_in  = idx_next;
                           step_in = CW'(1);
                           mode_in = M_DEL;
                           st_in   = B_RD;
                           if (cnt_ff != '0) begin
                              cnt_in = cnt_ff - CW'(1);
                           end
                        end
                     endcase
                  end else begin
                     idx_in  = idx_next;
                     step_in = step_ff + CW'(1);
                     st_in   = B_RD;
                  end
               end
               M_INS: begin
                  if (!used) begin
                     kv_we     = 1'b1;
                     meta_we   = 1'b1;
                     cnt_in    = cnt_ff + CW'(1);
                     status_in = ST_INSERTED;
                     st_in     = B_FIN;
                  end else begin
                     // richer resident gives way to the carried entry
                     if (mp_ff > CW'(sp)) begin
                        kv_we   = 1'b1;
                        meta_we = 1'b1;
                        mk_in   = rd_key;
                        mv_in   = rd_val;
                        ml_in   = rlen;
                        mp_in   = CW'(sp) + CW'(1);
                     end else begin
                        mp_in = mp_ff + CW'(1);
                     end
                     idx_in  = idx_next;
                     step_in = step_ff + CW'(1);
                     st_in   = B_RD;
                  end
               end
               default: begin
                  // backward shift into the hole, or close it
                  if (!used || sp == '0) begin
                     meta_we = 1'b1;
                     waddr   = hole_ff;
                     wmeta   = '0;
                     st_in   = B_FIN;
                  end else begin
                     kv_we   = 1'b1;
                     meta_we = 1'b1;
                     waddr   = hole_ff;
                     wkey    = rd_key;
                     wval    = rd_val;
                     wmeta   = {sp - IW'(1), rlen, 1'b1};
                     hole_in = idx_ff;
                     idx_in  = idx_next;
                     step_in = step_ff + CW'(1);
                     st_in   = B_RD;
                  end
               end
            endcase
         end
         // hand the result to the output register
         B_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = rv_ff;
               rsp_hash_in   = job_ff.hash;
               rsp_total_in  = 11'(cnt_ff);
               clr_in        = '0;
               sweep_in      = 1'b0;
               st_in         = sweep_ff ? B_CLR : B_IDLE;
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase

      // key not in the table: insert, refuse or report absent
      if (miss) begin
         if (job_ff.func == FUNC_PUT && !full) begin
            mode_in = M_INS;
            mp_in   = step_ff;
            st_in   = B_RD;
         end else begin
            status_in = (job_ff.func == FUNC_PUT) ? ST_FULL : ST_ABSENT;
            st_in     = B_FIN;
         end
      end

      // register writes; a capacity change empties the store
      if (csr_we) begin
         case (csr_index)
            CSR_CAP: begin
               cap_in   = csr_wdata[3:0];
               cnt_in   = '0;
               clr_in   = '0;
               sweep_in = 1'b0;
               st_in    = B_CLR;
            end
            default: begin
               fill_in = csr_wdata;
            end
         endcase
      end
   end

   // slot memories, one write address and one registered read
   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[waddr] <= wkey;
      end
      if (kv_we || val_we) begin
         val_mem[waddr] <= wval;
      end
      if (meta_we) begin
         meta_mem[waddr] <= wmeta;
      end
      rd_key  <= key_mem[idx_ff];
      rd_val  <= val_mem[idx_ff];
      rd_meta <= meta_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_CLR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         sweep_ff     <= 1'b0;
         cap_ff       <= 4'd10;
         fill_ff      <= 11'd1024;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         sweep_ff     <= sweep_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      job_ff        <= job_in;
      idx_ff        <= idx_in;
      hole_ff       <= hole_in;
      step_ff       <= step_in;
      mp_ff         <= mp_in;
      mk_ff         <= mk_in;
      mv_ff         <= mv_in;
      ml_ff         <= ml_in;
      status_ff     <= status_in;
      rv_ff         <= rv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_hash   = rsp_hash_ff;
   assign rsp_total  = rsp_total_ff;

endmodule

// ===== sv/robin_hood_hash_table_top.sv =====
// top level of the robin hood hash table: front hasher, queue, back sequencer
//
//   channel | direction | contents
//   req     | in        | tuser func; tdata key, key_len, value
//   rsp     | out       | tuser status; tdata result_value, key_hash, entry_total
//   csr     | in        | write enable, register index, write data
//
// hashing takes the request, runs one fnv multiply round per key byte, up to
// KEY_BYTES (eight by default), then pushes the job into the queue
// the back end reads each slot visited and then checks it, with one write address
// and one registered read per memory; it takes the job before the walk and hands
// over the result after it; a put of a new key visits the slot where its search
// stopped a second time; reset, a clear operation and a capacity write start a
// sweep over all SLOTS slots (1024 by default); no operation is taken during it
// a stalled result holds the back end; the queue lets the front keep hashing
module robin_hood_hash_table_top #(
   parameter int SLOTS      = rhh_pkg::SLOTS_DEF,
   parameter int KEY_BYTES  = rhh_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // key[63:0], key_len[67:64], value[99:68], zero fill
   input  logic [1:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // result_value[31:0], key_hash[95:32], entry_total[106:96]
   output logic [2:0]   rsp_tuser,   // status
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [10:0]  csr_wdata
);
   import rhh_pkg::*;

   logic        f_valid, f_ready, q_valid, q_pop;
   job_type     f_job, q_job;
   logic [31:0] r_value;
   logic [63:0] r_hash;
   logic [10:0] r_total;

   rhh_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser),
      .in_key     (req_tdata[63:0]),
      .in_key_len (req_tdata[67:64]),
      .in_value   (req_tdata[99:68]),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_job    (f_job)
   );

   rhh_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_job    (q_job)
   );

   rhh_back #(
      .SLOTS      (SLOTS),
      .KEY_BYTES  (KEY_BYTES),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_pop    (q_pop),
      .job        (q_job),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_value  (r_value),
      .rsp_hash   (r_hash),
      .rsp_total  (r_total)
   );

   assign rsp_tdata = {5'd0, r_total, r_hash, r_value};

   // a clear always reports an empty table
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_CLEARED |-> rsp_tdata[106:96] == 11'd0)
      else $error("clear result with entries left");

   // only a hit carries a value back
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FOUND |-> rsp_tdata[31:0] == 32'd0)
      else $error("value returned without a hit");

   // status codes stay within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_CLEARED)
      else $error("undefined status code");

endmodule
